@@ rtl/core/modular_lagrange_interpolation_core_defines.svh @@
// assertion macros for the lagrange core checker
`ifndef MODULAR_LAGRANGE_INTERPOLATION_CORE_DEFINES_SVH
`define MODULAR_LAGRANGE_INTERPOLATION_CORE_DEFINES_SVH

// same-cycle implication
`define MLI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lagrange core assertion failed");

// next-cycle implication
`define MLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lagrange core assertion failed");

`endif

@@ rtl/core/mli_pkg.sv @@
package mli_pkg;

  localparam int MAX_POINTS = 2048;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int VAL_W = 30;

  localparam logic [31:0] PRIME_P = 32'd998244353;
  localparam logic [29:0] EXP_BITS = 30'(PRIME_P - 32'd2);
  localparam int EXP_LEN = 30;
  localparam logic [63:0] BARRETT_MU = (64'd1 << 60) / 64'(PRIME_P);

  localparam logic [2:0] OP_DEN = 3'd0;
  localparam logic [2:0] OP_NUM = 3'd1;
  localparam logic [2:0] OP_ACC = 3'd2;
  localparam logic [2:0] OP_SQ  = 3'd3;
  localparam logic [2:0] OP_Y   = 3'd4;
  localparam logic [2:0] OP_TN  = 3'd5;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             init_term;
    logic             lat_xi;
    logic             mul_start;
    logic [2:0]       mul_op;
    logic             add_sum;
    logic             clr_sum;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
  } stat_t;

  function automatic logic [VAL_W-1:0] reduce32(input logic [31:0] a);
    logic [31:0] r;
    priority if (a >= 32'(4 * 64'(PRIME_P))) r = a - 32'(4 * 64'(PRIME_P));
    else if (a >= 32'(3 * 64'(PRIME_P))) r = a - 32'(3 * 64'(PRIME_P));
    else if (a >= 32'(2 * 64'(PRIME_P))) r = a - 32'(2 * 64'(PRIME_P));
    else if (a >= PRIME_P) r = a - PRIME_P;
    else r = a;
    return r[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] r;
    if (a >= b) r = {1'b0, a} - {1'b0, b};
    else r = {1'b0, a} + PRIME_P[VAL_W:0] - {1'b0, b};
    return r[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= PRIME_P[VAL_W:0]) s = s - PRIME_P[VAL_W:0];
    return s[VAL_W-1:0];
  endfunction

endpackage

@@ rtl/core/mli_modmul.sv @@
module mli_modmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [29:0] a,
  input  logic [29:0] b,
  output logic        done,
  output logic [29:0] res
);

  logic [3:0]  vld_r;
  logic [59:0] t1_r;
  logic [59:0] t2_r;
  logic [30:0] q_r;
  logic [31:0] r_r;
  logic [29:0] res_r;
  logic [61:0] qm;
  logic [60:0] qp;
  logic [31:0] rc;

  assign qm = 62'(t1_r[59:29]) * 62'(mli_pkg::BARRETT_MU[30:0]);
  assign qp = 61'(q_r) * 61'(mli_pkg::PRIME_P[29:0]);

  // barrett remainder is below three times the prime
  always_comb begin
    priority if (r_r >= 32'(2 * 64'(mli_pkg::PRIME_P))) rc = r_r - 32'(2 * 64'(mli_pkg::PRIME_P));
    else if (r_r >= mli_pkg::PRIME_P) rc = r_r - mli_pkg::PRIME_P;
    else rc = r_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    t1_r  <= 60'(a) * 60'(b);
    t2_r  <= t1_r;
    q_r   <= qm[61:31];
    r_r   <= t2_r[31:0] - qp[31:0];
    res_r <= rc[29:0];
  end

  assign done = vld_r[3];
  assign res  = res_r;

endmodule

@@ rtl/core/mli_datapath.sv @@
module mli_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mli_pkg::cmd_t        cmd,
  output mli_pkg::stat_t       stat,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_data,
  input  logic [31:0]          x_coord,
  input  logic [31:0]          y_value,
  output logic [29:0]          sum
);

  logic [29:0] x_mem [mli_pkg::MAX_POINTS];
  logic [29:0] y_mem [mli_pkg::MAX_POINTS];
  logic [29:0] xrd_r, yrd_r;
  logic [31:0] eval_r;
  logic [29:0] v;
  logic [29:0] xi_r, den_r, num_r, pw_r, sum_r;
  logic [2:0]  op_r;
  logic [29:0] ma, mb, mres;
  logic        mdone;

  assign v = mli_pkg::reduce32(eval_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r <= '0;
    end else if (cfg_we) begin
      eval_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_mem[cmd.wr_addr] <= mli_pkg::reduce32(x_coord);
      y_mem[cmd.wr_addr] <= mli_pkg::reduce32(y_value);
    end
    if (cmd.rd_en) begin
      xrd_r <= x_mem[cmd.rd_addr];
      yrd_r <= y_mem[cmd.rd_addr];
    end
  end

  always_comb begin
    unique case (cmd.mul_op)
      mli_pkg::OP_DEN: begin ma = den_r; mb = mli_pkg::mod_sub(xi_r, xrd_r); end
      mli_pkg::OP_NUM: begin ma = num_r; mb = mli_pkg::mod_sub(v, xrd_r); end
      mli_pkg::OP_ACC: begin ma = pw_r;  mb = den_r; end
      mli_pkg::OP_SQ:  begin ma = den_r; mb = den_r; end
      mli_pkg::OP_Y:   begin ma = pw_r;  mb = yrd_r; end
      default:         begin ma = pw_r;  mb = num_r; end
    endcase
  end

  mli_modmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .res   (mres)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul_start) op_r <= cmd.mul_op;
    if (cmd.lat_xi) xi_r <= xrd_r;
    if (cmd.init_term) begin
      den_r <= 30'd1;
      num_r <= 30'd1;
      pw_r  <= 30'd1;
    end else if (mdone) begin
      unique case (op_r)
        mli_pkg::OP_DEN, mli_pkg::OP_SQ: den_r <= mres;
        mli_pkg::OP_NUM:                 num_r <= mres;
        default:                         pw_r  <= mres;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.clr_sum) begin
      sum_r <= '0;
    end else if (cmd.add_sum) begin
      sum_r <= mli_pkg::mod_add(sum_r, pw_r);
    end
  end

  assign stat.mul_done = mdone;
  assign sum = sum_r;

endmodule

@@ rtl/core/mli_ctrl.sv @@
module mli_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           last_point,
  output logic           busy,
  output logic           out_valid,
  output logic           out_ovf,
  output mli_pkg::cmd_t  cmd,
  input  mli_pkg::stat_t stat
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_XI_RD  = 4'd1;
  localparam logic [3:0] S_XI_LAT = 4'd2;
  localparam logic [3:0] S_J_CHK  = 4'd3;
  localparam logic [3:0] S_J_DEN  = 4'd4;
  localparam logic [3:0] S_J_NUM  = 4'd5;
  localparam logic [3:0] S_P_CHK  = 4'd6;
  localparam logic [3:0] S_P_SQ   = 4'd7;
  localparam logic [3:0] S_Y_RD   = 4'd8;
  localparam logic [3:0] S_Y_MUL  = 4'd9;
  localparam logic [3:0] S_T_NUM  = 4'd10;
  localparam logic [3:0] S_SUM    = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;
  localparam logic [3:0] S_MWAIT  = 4'd13;

  localparam int CW = mli_pkg::CNT_W;
  localparam int IW = mli_pkg::IDX_W;

  logic [3:0]    state_r, state_nxt, ret_r, ret_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [4:0]    k_r, k_nxt;
  logic          ovf_r, ovf_nxt, oval_r, oval_nxt, oovf_r, oovf_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    ovf_nxt   = ovf_r;
    oval_nxt  = 1'b0;
    oovf_nxt  = oovf_r;
    cmd       = '0;
    cmd.mul_op  = mli_pkg::OP_DEN;
    cmd.wr_addr = cnt_r[IW-1:0];
    cmd.rd_addr = i_r[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (cnt_r < CW'(mli_pkg::MAX_POINTS)) begin
            cmd.load = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (last_point) begin
            cmd.clr_sum = 1'b1;
            i_nxt       = '0;
            state_nxt   = S_XI_RD;
          end
        end
      end
      S_XI_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.init_term = 1'b1;
        j_nxt         = '0;
        state_nxt     = S_XI_LAT;
      end
      S_XI_LAT: begin
        cmd.lat_xi = 1'b1;
        state_nxt  = S_J_CHK;
      end
      S_J_CHK: begin
        if (j_r == cnt_r) begin
          k_nxt     = '0;
          state_nxt = S_P_CHK;
        end else if (j_r == i_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = j_r[IW-1:0];
          state_nxt   = S_J_DEN;
        end
      end
      S_J_DEN: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = mli_pkg::OP_DEN;
        ret_nxt       = S_J_NUM;
        state_nxt     = S_MWAIT;
      end
      S_J_NUM: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = mli_pkg::OP_NUM;
        j_nxt         = j_r + 1'b1;
        ret_nxt       = S_J_CHK;
        state_nxt     = S_MWAIT;
      end
      S_P_CHK: begin
        if (k_r == 5'(mli_pkg::EXP_LEN)) begin
          state_nxt = S_Y_RD;
        end else if (mli_pkg::EXP_BITS[k_r]) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = mli_pkg::OP_ACC;
          ret_nxt       = S_P_SQ;
          state_nxt     = S_MWAIT;
        end else begin
          state_nxt = S_P_SQ;
        end
      end
      S_P_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = mli_pkg::OP_SQ;
        k_nxt         = k_r + 1'b1;
        ret_nxt       = S_P_CHK;
        state_nxt     = S_MWAIT;
      end
      S_Y_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_Y_MUL;
      end
      S_Y_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = mli_pkg::OP_Y;
        ret_nxt       = S_T_NUM;
        state_nxt     = S_MWAIT;
      end
      S_T_NUM: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = mli_pkg::OP_TN;
        ret_nxt       = S_SUM;
        state_nxt     = S_MWAIT;
      end
      S_SUM: begin
        cmd.add_sum = 1'b1;
        i_nxt       = i_r + 1'b1;
        state_nxt   = (i_r + 1'b1 == cnt_r) ? S_DONE : S_XI_RD;
      end
      S_DONE: begin
        oval_nxt  = 1'b1;
        oovf_nxt  = ovf_r;
        ovf_nxt   = 1'b0;
        cnt_nxt   = '0;
        state_nxt = S_IDLE;
      end
      S_MWAIT: begin
        if (stat.mul_done) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      cnt_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      ovf_r   <= 1'b0;
      oval_r  <= 1'b0;
      oovf_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      ovf_r   <= ovf_nxt;
      oval_r  <= oval_nxt;
      oovf_r  <= oovf_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = oval_r;
  assign out_ovf   = oovf_r;

endmodule

@@ rtl/core/modular_lagrange_interpolation_core.sv @@
// channel   ports                                  transfer
// input     start, busy, in_x_coord, in_y_value,   start & !busy
//           in_last_point
// result    out_valid, out_poly_value,             out_valid, one cycle
//           out_overflowed
// config    cfg_valid, cfg_ready, cfg_data         cfg_valid & cfg_ready
//
// a point without the last mark takes one cycle; busy stays low
// a marked point starts evaluation over the n stored points; busy stays high
// while it runs on the one shared modular multiplier
// (four-stage barrett pipeline, one operation in flight); result the cycle after
// reset is synchronous, active low; the result strobe cannot be stalled
module modular_lagrange_interpolation_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_x_coord,
  input  logic [31:0] in_y_value,
  input  logic        in_last_point,
  output logic        out_valid,
  output logic [29:0] out_poly_value,
  output logic        out_overflowed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  mli_pkg::cmd_t  cmd;
  mli_pkg::stat_t stat;

  assign cfg_ready = ~busy;

  mli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_point (in_last_point),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_ovf    (out_overflowed),
    .cmd        (cmd),
    .stat       (stat)
  );

  mli_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .x_coord  (in_x_coord),
    .y_value  (in_y_value),
    .sum      (out_poly_value)
  );

endmodule

@@ rtl/core/mli_checker.sv @@
`include "modular_lagrange_interpolation_core_defines.svh"

module mli_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_last_point,
  input logic        out_valid,
  input logic [29:0] out_poly_value
);

  `MLI_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `MLI_ASSERT_SAME(a_value_range, clk, rst_n, out_valid, out_poly_value < mli_pkg::PRIME_P[29:0])
  `MLI_ASSERT_NEXT(a_plain_point, clk, rst_n, start && !busy && !in_last_point, !busy)
  `MLI_ASSERT_NEXT(a_last_busy, clk, rst_n, start && !busy && in_last_point, busy && !out_valid)
  `MLI_ASSERT_SAME(a_result_after_busy, clk, rst_n, out_valid, $past(busy))

endmodule

bind modular_lagrange_interpolation_core mli_checker u_mli_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_last_point  (in_last_point),
  .out_valid      (out_valid),
  .out_poly_value (out_poly_value)
);

@@ test/tb_modular_lagrange_interpolation_core.sv @@
module tb_modular_lagrange_interpolation_core;

  typedef struct {
    logic [29:0] value;
    logic        ovf;
  } lagrange_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_x_coord;
  logic [31:0] in_y_value;
  logic        in_last_point;
  logic        out_valid;
  logic [29:0] out_poly_value;
  logic        out_overflowed;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  logic [29:0]      set_x[$];
  logic [29:0]      set_y[$];
  logic             set_ovf;
  logic [31:0]      eval_reg;
  lagrange_result_t pending_results[$];
  int               mismatches;
  int               points_sent;
  bit               no_gaps;
  longint           idle_cycles;
  longint           idle_limit;

  modular_lagrange_interpolation_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x_coord(in_x_coord), .in_y_value(in_y_value), .in_last_point(in_last_point),
    .out_valid(out_valid), .out_poly_value(out_poly_value),
    .out_overflowed(out_overflowed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [29:0] fmul(logic [29:0] a, logic [29:0] b);
    logic [63:0] prod;
    prod = {34'd0, a} * {34'd0, b};
    return 30'(prod % 64'(mli_pkg::PRIME_P));
  endfunction

  function automatic logic [29:0] fsub(logic [29:0] a, logic [29:0] b);
    logic [31:0] r;
    r = (a >= b) ? 32'(a) - 32'(b) : 32'(a) + mli_pkg::PRIME_P - 32'(b);
    return r[29:0];
  endfunction

  function automatic logic [29:0] finv(logic [29:0] a);
    logic [29:0] acc;
    logic [29:0] base;
    logic [31:0] e;
    acc = 30'd1;
    base = a;
    e = mli_pkg::PRIME_P - 32'd2;
    while (e != 0) begin
      if (e[0]) acc = fmul(acc, base);
      base = fmul(base, base);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [29:0] fold(logic [31:0] a);
    return 30'(a % mli_pkg::PRIME_P);
  endfunction

  function automatic logic [29:0] interpolate_set();
    logic [29:0] v;
    logic [29:0] sum;
    logic [29:0] den;
    logic [29:0] num;
    v = fold(eval_reg);
    sum = 30'd0;
    for (int i = 0; i < set_x.size(); i++) begin
      den = 30'd1;
      num = 30'd1;
      for (int j = 0; j < set_x.size(); j++) begin
        if (j != i) begin
          den = fmul(den, fsub(set_x[i], set_x[j]));
          num = fmul(num, fsub(v, set_x[j]));
        end
      end
      sum = 30'((64'(sum) + 64'(fmul(fmul(finv(den), set_y[i]), num)))
                % 64'(mli_pkg::PRIME_P));
    end
    return sum;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(120, 20);
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return $urandom_range(12);
      1: return mli_pkg::PRIME_P + $urandom_range(12);
      2: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic last);
    int gap;
    lagrange_result_t res;
    longint n;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_x_coord <= x;
    in_y_value <= y;
    in_last_point <= last;
    do @(posedge clk); while (busy);
    points_sent++;
    if (set_x.size() < mli_pkg::MAX_POINTS) begin
      set_x.push_back(fold(x));
      set_y.push_back(fold(y));
    end else begin
      set_ovf = 1'b1;
    end
    if (last) begin
      n = set_x.size();
      idle_limit = 4 * (11 * n * n + 309 * n) + 20000;
      res.value = interpolate_set();
      res.ovf = set_ovf;
      pending_results.push_back(res);
      set_x.delete();
      set_y.delete();
      set_ovf = 1'b0;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_eval_point(logic [31:0] value);
    drain();
    while (busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    eval_reg = value;
    cfg_valid <= 1'b0;
    cfg_data <= $urandom;
    @(posedge clk);
  endtask

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_point(pick_coord(), $urandom, i == n - 1);
  endtask

  task automatic test_single_point();
    write_eval_point(32'd0);
    send_point(32'd5, 32'hFFFF_FFFF, 1'b1);
    send_point(32'hFFFF_FFFF, 32'd0, 1'b1);
  endtask

  task automatic test_field_extremes();
    write_eval_point(32'hFFFF_FFFF);
    send_point(32'd0, 32'd0, 1'b0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_point(mli_pkg::PRIME_P - 32'd1, mli_pkg::PRIME_P, 1'b0);
    send_point(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
  endtask

  task automatic test_duplicate_x();
    write_eval_point(mli_pkg::PRIME_P);
    send_point(32'd7, 32'd100, 1'b0);
    send_point(mli_pkg::PRIME_P + 32'd7, 32'd200, 1'b0);
    send_point(32'd9, 32'd300, 1'b1);
    send_point(32'd3, 32'd1, 1'b0);
    send_point(32'd3, 32'd2, 1'b1);
  endtask

  task automatic test_eval_on_node();
    write_eval_point(mli_pkg::PRIME_P - 32'd1);
    send_point(mli_pkg::PRIME_P - 32'd1, 32'd42, 1'b0);
    send_point(32'd1, 32'd43, 1'b0);
    send_point(32'd2, 32'd44, 1'b1);
  endtask

  task automatic test_random_sets();
    int n;
    no_gaps = 1'b0;
    while (points_sent < 130) begin
      if ($urandom_range(3) == 0) write_eval_point($urandom_range(1) ? $urandom : pick_coord());
      no_gaps = ($urandom_range(4) == 0);
      n = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(6, 1);
      send_set(n);
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    lagrange_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: poly_value %0d overflowed %0d",
                   out_poly_value, out_overflowed);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_poly_value !== exp_res.value || out_overflowed !== exp_res.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: poly_value exp %0d got %0d, overflowed exp %0d got %0d",
                     exp_res.value, out_poly_value, exp_res.ovf, out_overflowed);
        end
        idle_limit = 20000;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > idle_limit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_x_coord <= '0;
    in_y_value <= '0;
    in_last_point <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    eval_reg = 32'd0;
    set_ovf = 1'b0;
    mismatches = 0;
    points_sent = 0;
    no_gaps = 1'b0;
    idle_limit = 20000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_point();
    test_field_extremes();
    test_duplicate_x();
    test_eval_on_node();
    test_random_sets();
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
